// File: hw/rtl/sraf_pkg.sv
// Shared types and constants for the region access filter.
`timescale 1ns / 1ps
package sraf_pkg;

  localparam int NumRegionsDef = 9;
  localparam int AddrWidthDef  = 40;

  typedef enum logic [1:0] {
    KIND_RD  = 2'd0,
    KIND_WR  = 2'd1,
    KIND_CHK = 2'd2,
    KIND_BAD = 2'd3
  } kind_e;

  // Register offsets (word aligned).
  localparam logic [15:0] OFF_BUILD   = 16'h000;
  localparam logic [15:0] OFF_ACTION  = 16'h004;
  localparam logic [15:0] OFF_GATE    = 16'h008;
  localparam logic [15:0] OFF_SPEC    = 16'h00C;
  localparam logic [15:0] OFF_INTSTAT = 16'h010;
  localparam logic [15:0] OFF_INTCLR  = 16'h014;
  localparam logic [15:0] OFF_FADDRLO = 16'h020;
  localparam logic [15:0] OFF_FADDRHI = 16'h024;
  localparam logic [15:0] OFF_FCTRL   = 16'h028;
  localparam logic [15:0] OFF_FID     = 16'h02C;
  localparam logic [15:0] OFF_REGION  = 16'h100;
  localparam logic [15:0] OFF_IDLO    = 16'hFD0;
  localparam logic [15:0] OFF_IDHI    = 16'hFFC;

  // Offsets within one region slot.
  localparam logic [4:0] RO_BASE_LO = 5'h00;
  localparam logic [4:0] RO_BASE_HI = 5'h04;
  localparam logic [4:0] RO_TOP_LO  = 5'h08;
  localparam logic [4:0] RO_TOP_HI  = 5'h0C;
  localparam logic [4:0] RO_ATTR    = 5'h10;
  localparam logic [4:0] RO_IDACC   = 5'h14;

  // Identification byte for word index 0..11.
  function automatic logic [7:0] id_byte(input logic [3:0] idx);
    logic [7:0] b;
    begin
      case (idx)
        4'd4:  b = 8'h60;
        4'd5:  b = 8'hb4;
        4'd6:  b = 8'h2b;
        4'd8:  b = 8'h0d;
        4'd9:  b = 8'hf0;
        4'd10: b = 8'h05;
        4'd11: b = 8'hb1;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

  // Front to back queue entry.
  typedef struct packed {
    kind_e        kind;
    logic         size_ok;
    logic         reg_ok;
    logic [15:0]  off;
    logic [31:0]  wdata;
    logic [63:0]  addr;
    logic         tsec;
    logic [3:0]   req;
    logic         twr;
  } op_t;

endpackage

// File: hw/rtl/secure_region_access_filter_top.sv
// Top level of the region access filter.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | kind .. txn_write
//  out     | output    | out_valid_o/stall_i| read_data .. irq_level
//
// The back end handles an item in a region compare step, then a pick and
// update step; it takes one item at a time, and a stalled output holds the pick.
// A two-entry queue separates front and back; the output register frees
// as its result is taken. Reset is asynchronous, active low.
`timescale 1ns / 1ps
module secure_region_access_filter_top #(
  parameter int NumRegions = sraf_pkg::NumRegionsDef,
  parameter int AddrWidth  = sraf_pkg::AddrWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [15:0]          reg_offset_i,
  input  logic [3:0]           access_size_i,
  input  logic                 bus_secure_i,
  input  logic [31:0]          write_data_i,
  input  logic [AddrWidth-1:0] txn_address_i,
  input  logic                 txn_secure_i,
  input  logic [3:0]           txn_requester_i,
  input  logic                 txn_write_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          read_data_o,
  output logic                 bus_error_o,
  output logic                 txn_allowed_o,
  output logic                 irq_level_o
);

  logic          op_valid, op_pop;
  sraf_pkg::op_t op;

  sraf_front #(.AddrWidth(AddrWidth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .reg_offset_i,
    .access_size_i, .bus_secure_i, .write_data_i, .txn_address_i,
    .txn_secure_i, .txn_requester_i, .txn_write_i,
    .op_valid_o(op_valid), .op_pop_i(op_pop), .op_o(op)
  );

  sraf_back #(.NumRegions(NumRegions), .AddrWidth(AddrWidth)) u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_pop_o(op_pop), .op_i(op),
    .out_valid_o, .out_stall_i, .read_data_o, .bus_error_o, .txn_allowed_o,
    .irq_level_o
  );

endmodule

// File: hw/rtl/sraf_front.sv
// Front end: accepts items, classifies them, and queues them for the back end.
`timescale 1ns / 1ps
module sraf_front #(
  parameter int AddrWidth = sraf_pkg::AddrWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           kind_i,
  input  logic [15:0]          reg_offset_i,
  input  logic [3:0]           access_size_i,
  input  logic                 bus_secure_i,
  input  logic [31:0]          write_data_i,
  input  logic [AddrWidth-1:0] txn_address_i,
  input  logic                 txn_secure_i,
  input  logic [3:0]           txn_requester_i,
  input  logic                 txn_write_i,
  output logic                 op_valid_o,
  input  logic                 op_pop_i,
  output sraf_pkg::op_t        op_o
);

  // Two-entry queue.
  sraf_pkg::op_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, rd_d, wr_q, wr_d;
  logic       push;
  sraf_pkg::op_t op_new;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    op_new         = '0;
    op_new.kind    = sraf_pkg::kind_e'(kind_i);
    op_new.size_ok = (access_size_i == 4'd4);
    op_new.reg_ok  = bus_secure_i || ({reg_offset_i[15:2], 2'b00} >= sraf_pkg::OFF_IDLO);
    op_new.off     = {reg_offset_i[15:2], 2'b00};
    op_new.wdata   = write_data_i;
    op_new.addr    = 64'(txn_address_i);
    op_new.tsec    = txn_secure_i;
    op_new.req     = txn_requester_i;
    op_new.twr     = txn_write_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    wr_d  = wr_q;
    if (push) begin
      wr_d = ~wr_q;
    end
    if (op_pop_i) begin
      rd_d = ~rd_q;
    end
    cnt_d = cnt_q + 2'(push) - 2'(op_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= op_new;
    end
  end

  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = q_q[rd_q];

endmodule

// File: hw/rtl/sraf_back.sv
// Back end: register file, region match and result register.
`timescale 1ns / 1ps
module sraf_back #(
  parameter int NumRegions = sraf_pkg::NumRegionsDef,
  parameter int AddrWidth  = sraf_pkg::AddrWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  input  sraf_pkg::op_t op_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   read_data_o,
  output logic          bus_error_o,
  output logic          txn_allowed_o,
  output logic          irq_level_o
);

  localparam int RW = (NumRegions > 1) ? $clog2(NumRegions) : 1;
  localparam logic [AddrWidth-1:0] AddrOnes = '1;

  logic [AddrWidth-1:0] base_q [NumRegions];
  logic [AddrWidth-1:0] top_q  [NumRegions];
  logic [31:0]          attr_q [NumRegions];
  logic [31:0]          ida_q  [NumRegions];
  logic [1:0]  action_q;
  logic        gate_q;
  logic [31:0] spec_q;
  logic        pend_q;
  logic [AddrWidth-1:0] faddr_q;
  logic [2:0]  fflags_q;
  logic [3:0]  freq_q;

  // Stage 1 registers: per-region hit vector, then the pick in stage 2.
  logic                 s1_q;
  logic [NumRegions-1:0] hit_q;
  logic                 busy;

  logic        out_v_q;
  logic [31:0] rdata_q;
  logic        berr_q, allow_q;

  // Item waits in the queue head during its match cycle; popped at finish.
  logic finish;
  assign busy     = s1_q;
  assign finish   = s1_q && (!out_v_q || !out_stall_i);
  assign op_pop_o = finish;

  logic [AddrWidth-1:0] a;
  assign a = op_i.addr[AddrWidth-1:0];

  logic [NumRegions-1:0] hit_d;
  always_comb begin
    for (int i = 0; i < NumRegions; i++) begin
      hit_d[i] = (i == 0 || attr_q[i][3:0] != 4'd0) && a >= base_q[i] && a <= top_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else if (finish) begin
      s1_q <= 1'b0;
    end else if (op_valid_i && !busy) begin
      s1_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid_i && !busy) begin
      hit_q <= hit_d;
    end
  end

  // Priority pick and permission.
  logic allowed;
  always_comb begin
    allowed = 1'b0;
    for (int i = 0; i < NumRegions; i++) begin
      if (hit_q[i]) begin
        if (op_i.tsec) begin
          allowed = op_i.twr ? attr_q[i][31] : attr_q[i][30];
        end else begin
          allowed = ida_q[i][{op_i.twr, op_i.req}];
        end
      end
    end
    if (!gate_q) allowed = 1'b0;
  end

  // Register decode.
  logic [15:0] roff;
  logic [4:0]  ro;
  logic [10:0] rslot;
  logic        in_reg;
  logic [RW-1:0] ridx;
  assign roff   = op_i.off - sraf_pkg::OFF_REGION;
  assign ro     = roff[4:0];
  assign rslot  = roff[15:5];
  assign in_reg = (op_i.off >= sraf_pkg::OFF_REGION) && (32'(rslot) < NumRegions);
  assign ridx   = RW'(rslot);

  logic [31:0] rd;
  logic [63:0] wide;
  always_comb begin
    rd = '0;
    wide = '0;
    if (in_reg) begin
      case (ro)
        sraf_pkg::RO_BASE_LO: begin wide = 64'(base_q[ridx]); rd = wide[31:0]; end
        sraf_pkg::RO_BASE_HI: begin wide = 64'(base_q[ridx]); rd = wide[63:32]; end
        sraf_pkg::RO_TOP_LO:  begin wide = 64'(top_q[ridx]);  rd = wide[31:0]; end
        sraf_pkg::RO_TOP_HI:  begin wide = 64'(top_q[ridx]);  rd = wide[63:32]; end
        sraf_pkg::RO_ATTR:    rd = attr_q[ridx];
        sraf_pkg::RO_IDACC:   rd = ida_q[ridx];
        default:              rd = '0;
      endcase
    end else if (op_i.off >= sraf_pkg::OFF_IDLO && op_i.off <= sraf_pkg::OFF_IDHI) begin
      rd = 32'(sraf_pkg::id_byte(4'(op_i.off[15:2] - sraf_pkg::OFF_IDLO[15:2])));
    end else begin
      wide = 64'(faddr_q);
      unique case (op_i.off)
        sraf_pkg::OFF_BUILD:
          rd = {18'd0, 6'(AddrWidth - 1), 3'd0, 5'(NumRegions - 1)};
        sraf_pkg::OFF_ACTION:  rd = {30'd0, action_q};
        sraf_pkg::OFF_GATE:    rd = {15'd0, gate_q, 15'd0, gate_q};
        sraf_pkg::OFF_SPEC:    rd = spec_q;
        sraf_pkg::OFF_INTSTAT: rd = {31'd0, pend_q};
        sraf_pkg::OFF_FADDRLO: rd = wide[31:0];
        sraf_pkg::OFF_FADDRHI: rd = wide[63:32];
        sraf_pkg::OFF_FCTRL:
          rd = {7'd0, fflags_q[2], 2'd0, fflags_q[1], fflags_q[0], 20'd0};
        sraf_pkg::OFF_FID:     rd = {28'd0, freq_q};
        default:               rd = '0;
      endcase
    end
  end

  logic do_rd, do_wr, do_chk;
  assign do_rd  = op_i.kind == sraf_pkg::KIND_RD && op_i.size_ok && op_i.reg_ok;
  assign do_wr  = finish && op_i.kind == sraf_pkg::KIND_WR && op_i.size_ok && op_i.reg_ok;
  assign do_chk = finish && op_i.kind == sraf_pkg::KIND_CHK;

  logic [63:0] wlo, whi;
  always_comb begin
    wlo = '0;
    whi = '0;
    if (in_reg) begin
      wlo = (ro == sraf_pkg::RO_BASE_LO || ro == sraf_pkg::RO_BASE_HI) ?
            64'(base_q[ridx]) : 64'(top_q[ridx]);
    end
    whi = {op_i.wdata, wlo[31:0]};
    wlo = {wlo[63:32], op_i.wdata};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegions; i++) begin
        base_q[i] <= '0;
        top_q[i]  <= (i == 0) ? AddrOnes : '0;
        attr_q[i] <= (i == 0) ? 32'hC000_0000 : '0;
        ida_q[i]  <= (i == 0) ? 32'hFFFF_FFFF : '0;
      end
      action_q <= '0;
      gate_q   <= 1'b0;
      spec_q   <= '0;
      pend_q   <= 1'b0;
      faddr_q  <= '0;
      fflags_q <= '0;
      freq_q   <= '0;
    end else begin
      if (do_wr) begin
        if (in_reg) begin
          case (ro)
            sraf_pkg::RO_BASE_LO: base_q[ridx] <= wlo[AddrWidth-1:0];
            sraf_pkg::RO_BASE_HI: base_q[ridx] <= whi[AddrWidth-1:0];
            sraf_pkg::RO_TOP_LO:  top_q[ridx]  <= wlo[AddrWidth-1:0];
            sraf_pkg::RO_TOP_HI:  top_q[ridx]  <= whi[AddrWidth-1:0];
            sraf_pkg::RO_ATTR:    attr_q[ridx] <= op_i.wdata;
            sraf_pkg::RO_IDACC:   ida_q[ridx]  <= op_i.wdata;
            default: ;
          endcase
        end else begin
          unique case (op_i.off)
            sraf_pkg::OFF_ACTION:  action_q <= op_i.wdata[1:0];
            sraf_pkg::OFF_GATE:    gate_q   <= op_i.wdata[0];
            sraf_pkg::OFF_SPEC:    spec_q   <= op_i.wdata;
            sraf_pkg::OFF_INTCLR:  if (op_i.wdata[0]) pend_q <= 1'b0;
            default: ;
          endcase
        end
      end
      if (do_chk && !allowed) begin
        faddr_q  <= a;
        fflags_q <= {op_i.twr, !op_i.tsec, 1'b1};
        freq_q   <= op_i.tsec ? 4'd0 : op_i.req;
        pend_q   <= 1'b1;
      end
    end
  end

  // Output register; irq reflects state after the item.
  logic irq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (finish) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  logic pend_n;
  logic act_n;
  always_comb begin
    pend_n = pend_q;
    act_n  = action_q[1];
    if (do_wr && !in_reg && op_i.off == sraf_pkg::OFF_INTCLR && op_i.wdata[0]) pend_n = 1'b0;
    if (do_wr && !in_reg && op_i.off == sraf_pkg::OFF_ACTION) act_n = op_i.wdata[1];
    if (do_chk && !allowed) pend_n = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      rdata_q <= do_rd ? rd : '0;
      berr_q  <= (op_i.kind == sraf_pkg::KIND_RD || op_i.kind == sraf_pkg::KIND_WR) &&
                 !op_i.size_ok;
      allow_q <= (op_i.kind == sraf_pkg::KIND_CHK) && allowed;
      irq_q   <= act_n & pend_n;
    end
  end

  assign out_valid_o   = out_v_q;
  assign read_data_o   = rdata_q;
  assign bus_error_o   = berr_q;
  assign txn_allowed_o = allow_q;
  assign irq_level_o   = irq_q;

endmodule

// File: sim/secure_region_access_filter_top_test.sv
// Self-checking bench for the region access filter: predicted results vs block outputs.
`timescale 1ns / 1ps
module secure_region_access_filter_top_test;

  localparam int NR = sraf_pkg::NumRegionsDef;
  localparam int AW = sraf_pkg::AddrWidthDef;
  localparam logic [39:0] AMASK = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] LAST_SLOT = 16'(sraf_pkg::OFF_REGION + 16'h20 * (NR - 1));

  typedef struct packed {
    logic [31:0] rdata;
    logic        berr;
    logic        allowed;
    logic        irq;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] kind_i = '0;
  logic [15:0] reg_offset_i = '0;
  logic [3:0] access_size_i = '0;
  logic bus_secure_i = 1'b0;
  logic [31:0] write_data_i = '0;
  logic [AW-1:0] txn_address_i = '0;
  logic txn_secure_i = 1'b0;
  logic [3:0] txn_requester_i = '0;
  logic txn_write_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [31:0] read_data_o;
  logic bus_error_o, txn_allowed_o, irq_level_o;

  secure_region_access_filter_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // firewall shadow state
  logic [39:0] sh_base[NR];
  logic [39:0] sh_top[NR];
  logic [31:0] sh_attr[NR];
  logic [31:0] sh_idacc[NR];
  logic [1:0]  sh_action;
  logic        sh_gate;
  logic [31:0] sh_spec;
  logic        sh_pend;
  logic [39:0] sh_faddr;
  logic [2:0]  sh_fflags;
  logic [3:0]  sh_freq;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int n_sent = 0, n_checked = 0, n_allowed = 0, n_denied = 0;
  logic hold_rx = 1'b0;
  logic stall_enable = 1'b1;

  function automatic logic firewall_decide(logic [39:0] a, logic s, logic [3:0] r, logic w);
    for (int i = NR - 1; i >= 0; i--) begin
      if (i != 0 && sh_attr[i][3:0] == 4'd0) continue;
      if (a >= sh_base[i] && a <= sh_top[i]) begin
        if (s) return sh_attr[i][w ? 31 : 30];
        return sh_idacc[i][(w ? 16 : 0) + r];
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] shadow_read(logic [15:0] off);
    int r, ro;
    if (off >= sraf_pkg::OFF_REGION) begin
      r = (off - sraf_pkg::OFF_REGION) / 32;
      ro = (off - sraf_pkg::OFF_REGION) % 32;
      if (r < NR) begin
        case (ro)
          sraf_pkg::RO_BASE_LO: return sh_base[r][31:0];
          sraf_pkg::RO_BASE_HI: return {24'd0, sh_base[r][39:32]};
          sraf_pkg::RO_TOP_LO:  return sh_top[r][31:0];
          sraf_pkg::RO_TOP_HI:  return {24'd0, sh_top[r][39:32]};
          sraf_pkg::RO_ATTR:    return sh_attr[r];
          sraf_pkg::RO_IDACC:   return sh_idacc[r];
          default:              return 32'd0;
        endcase
      end
    end
    if (off >= sraf_pkg::OFF_IDLO && off <= sraf_pkg::OFF_IDHI) begin
      case (((off - sraf_pkg::OFF_IDLO) / 4) % 12)
        4: return 32'h60;
        5: return 32'hb4;
        6: return 32'h2b;
        8: return 32'h0d;
        9: return 32'hf0;
        10: return 32'h05;
        11: return 32'hb1;
        default: return 32'd0;
      endcase
    end
    case (off)
      sraf_pkg::OFF_BUILD:   return 32'((NR - 1) | ((AW - 1) << 8));
      sraf_pkg::OFF_ACTION:  return {30'd0, sh_action};
      sraf_pkg::OFF_GATE:    return {15'd0, sh_gate, 15'd0, sh_gate};
      sraf_pkg::OFF_SPEC:    return sh_spec;
      sraf_pkg::OFF_INTSTAT: return {31'd0, sh_pend};
      sraf_pkg::OFF_FADDRLO: return sh_faddr[31:0];
      sraf_pkg::OFF_FADDRHI: return {24'd0, sh_faddr[39:32]};
      sraf_pkg::OFF_FCTRL:
        return {7'd0, sh_fflags[2], 2'd0, sh_fflags[1], sh_fflags[0], 20'd0};
      sraf_pkg::OFF_FID:     return {28'd0, sh_freq};
      default:               return 32'd0;
    endcase
  endfunction

  function automatic void shadow_write(logic [15:0] off, logic [31:0] v);
    int r, ro;
    if (off >= sraf_pkg::OFF_REGION) begin
      r = (off - sraf_pkg::OFF_REGION) / 32;
      ro = (off - sraf_pkg::OFF_REGION) % 32;
      if (r < NR) begin
        case (ro)
          sraf_pkg::RO_BASE_LO: sh_base[r][31:0] = v;
          sraf_pkg::RO_BASE_HI: sh_base[r][39:32] = v[7:0];
          sraf_pkg::RO_TOP_LO:  sh_top[r][31:0] = v;
          sraf_pkg::RO_TOP_HI:  sh_top[r][39:32] = v[7:0];
          sraf_pkg::RO_ATTR:    sh_attr[r] = v;
          sraf_pkg::RO_IDACC:   sh_idacc[r] = v;
          default: ;
        endcase
        return;
      end
    end
    case (off)
      sraf_pkg::OFF_ACTION: sh_action = v[1:0];
      sraf_pkg::OFF_GATE:   sh_gate = v[0];
      sraf_pkg::OFF_SPEC:   sh_spec = v;
      sraf_pkg::OFF_INTCLR: if (v[0]) sh_pend = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic verdict_t firewall_step(logic [1:0] k, logic [15:0] offr, logic [3:0] sz,
                                             logic bs, logic [31:0] wd, logic [39:0] a,
                                             logic ts, logic [3:0] rq, logic tw);
    verdict_t v;
    logic [15:0] off;
    v = '0;
    off = {offr[15:2], 2'b00};
    if (k == sraf_pkg::KIND_RD || k == sraf_pkg::KIND_WR) begin
      if (sz != 4'd4) v.berr = 1'b1;
      else if (!bs && off < sraf_pkg::OFF_IDLO) ;
      else if (k == sraf_pkg::KIND_RD) v.rdata = shadow_read(off);
      else shadow_write(off, wd);
    end else if (k == sraf_pkg::KIND_CHK) begin
      v.allowed = sh_gate && firewall_decide(a, ts, rq, tw);
      if (!v.allowed) begin
        sh_faddr = a;
        sh_fflags = {tw, ~ts, 1'b1};
        sh_freq = ts ? 4'd0 : rq;
        sh_pend = 1'b1;
      end
    end
    v.irq = sh_action[1] & sh_pend;
    return v;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
  endfunction

  // valid stays up between back-to-back transfers; it drops only for a gap
  task automatic send_item(logic [1:0] k, logic [15:0] off, logic [3:0] sz, logic bs,
                           logic [31:0] wd, logic [39:0] a, logic ts, logic [3:0] rq,
                           logic tw, bit gaps = 1'b1);
    int g;
    g = gaps ? short_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    reg_offset_i <= off;
    access_size_i <= sz;
    bus_secure_i <= bs;
    write_data_i <= wd;
    txn_address_i <= a;
    txn_secure_i <= ts;
    txn_requester_i <= rq;
    txn_write_i <= tw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_verdicts.push_back(firewall_step(k, off, sz, bs, wd, a, ts, rq, tw));
    n_sent++;
    if (k == sraf_pkg::KIND_CHK) begin
      if (pending_verdicts[$].allowed) n_allowed++;
      else n_denied++;
    end
  endtask

  task automatic reg_wr(logic [15:0] off, logic [31:0] v);
    send_item(sraf_pkg::KIND_WR, off, 4'd4, 1'b1, v, '0, 1'b0, 4'd0, 1'b0);
  endtask

  task automatic reg_rd(logic [15:0] off, logic bs = 1'b1);
    send_item(sraf_pkg::KIND_RD, off, 4'd4, bs, $urandom, '0, 1'b0, 4'd0, 1'b0);
  endtask

  task automatic txn(logic [39:0] a, logic s, logic [3:0] r, logic w);
    send_item(sraf_pkg::KIND_CHK, 16'($urandom), 4'($urandom), 1'($urandom), $urandom,
              a, s, r, w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = pending_verdicts.pop_front();
        n_checked++;
        if (read_data_o !== e.rdata) begin
          $error("read_data exp %h got %h", e.rdata, read_data_o); errors++;
        end
        if (bus_error_o !== e.berr) begin
          $error("bus_error exp %b got %b", e.berr, bus_error_o); errors++;
        end
        if (txn_allowed_o !== e.allowed) begin
          $error("txn_allowed exp %b got %b", e.allowed, txn_allowed_o); errors++;
        end
        if (irq_level_o !== e.irq) begin
          $error("irq_level exp %b got %b", e.irq, irq_level_o); errors++;
        end
      end
    end
  end

  // receiver stall: random, forced high during a hold-off, or held low while stalls are disabled
  always @(posedge clk_i) begin
    int n;
    n = $urandom_range(0, 19);
    if (hold_rx) out_stall_i <= 1'b1;
    else if (!stall_enable) out_stall_i <= 1'b0;
    else if (n == 0) out_stall_i <= 1'b1;
    else if (n < 6) out_stall_i <= ~out_stall_i;
    else if (n < 12) out_stall_i <= 1'b0;
  end

  task automatic test_directed_registers();
    reg_rd(sraf_pkg::OFF_BUILD);
    reg_rd(sraf_pkg::OFF_IDLO);
    reg_rd(sraf_pkg::OFF_IDHI);
    reg_rd(16'hFE3, 1'b0);                  // non-secure id read, low bits dropped
    reg_rd(sraf_pkg::OFF_ACTION, 1'b0);     // non-secure below id area
    send_item(sraf_pkg::KIND_RD, sraf_pkg::OFF_BUILD, 4'd8, 1'b1, '0, '0,
              1'b0, 4'd0, 1'b0);
    send_item(sraf_pkg::KIND_WR, sraf_pkg::OFF_GATE, 4'd1, 1'b1, 32'h1, '0,
              1'b0, 4'd0, 1'b0);
    send_item(sraf_pkg::KIND_BAD, sraf_pkg::OFF_GATE, 4'd4, 1'b1, 32'h1, AMASK,
              1'b1, 4'hF, 1'b1);
    reg_wr(sraf_pkg::OFF_BUILD, 32'hFFFF_FFFF); // read only
    reg_wr(sraf_pkg::OFF_SPEC, 32'hFFFF_FFFF);
    reg_rd(sraf_pkg::OFF_SPEC);
    txn(40'h0, 1'b1, 4'd0, 1'b0);   // gate closed
    reg_wr(sraf_pkg::OFF_ACTION, 32'h3);
    reg_wr(sraf_pkg::OFF_GATE, 32'h1);
    reg_rd(sraf_pkg::OFF_GATE);
    reg_rd(sraf_pkg::OFF_FADDRLO);
    reg_rd(sraf_pkg::OFF_FCTRL);
    reg_wr(sraf_pkg::OFF_INTCLR, 32'h1);
    reg_rd(sraf_pkg::OFF_INTSTAT);
  endtask

  task automatic test_directed_regions();
    reg_wr(LAST_SLOT + sraf_pkg::RO_BASE_LO, 32'h0000_1000);
    reg_wr(LAST_SLOT + sraf_pkg::RO_BASE_HI, 32'hFFFF_FF00);
    reg_wr(LAST_SLOT + sraf_pkg::RO_TOP_LO, 32'hFFFF_FFFF);
    reg_wr(LAST_SLOT + sraf_pkg::RO_TOP_HI, 32'hFFFF_FFFF);
    reg_wr(LAST_SLOT + sraf_pkg::RO_ATTR, 32'h4000_0001);
    reg_wr(LAST_SLOT + sraf_pkg::RO_IDACC, 32'h8000_0001);
    reg_rd(LAST_SLOT + sraf_pkg::RO_TOP_HI);
    txn(AMASK, 1'b1, 4'd0, 1'b1);   // secure write denied
    txn(AMASK, 1'b0, 4'hF, 1'b1);
    txn(40'h1000, 1'b0, 4'd0, 1'b0);
    txn(40'h0FFF, 1'b0, 4'd5, 1'b1);
    reg_rd(sraf_pkg::OFF_FID);
    reg_rd(sraf_pkg::OFF_FADDRHI);
    reg_rd(16'(sraf_pkg::OFF_REGION + 16'h20 * NR)); // unused slot
  endtask

  function automatic logic [15:0] rand_offset();
    int p;
    p = $urandom_range(0, 9);
    if (p < 5)
      return 16'(sraf_pkg::OFF_REGION + 16'h20 * $urandom_range(0, NR) +
                 $urandom_range(0, 31));
    if (p < 8) return 16'($urandom_range(0, 16'h3F));
    if (p < 9) return 16'($urandom_range(sraf_pkg::OFF_IDLO, 16'hFFFF));
    return 16'($urandom);
  endfunction

  function automatic logic [39:0] rand_addr();
    int r;
    r = $urandom_range(0, NR - 1);
    case ($urandom_range(0, 3))
      0: return sh_base[r];
      1: return sh_top[r];
      2: return sh_base[r] + 40'($urandom_range(0, 3)) - 40'd1;
      default: return {8'($urandom), $urandom};
    endcase
  endfunction

  task automatic random_item(bit gaps);
    int p;
    logic [15:0] off;
    p = $urandom_range(0, 99);
    off = rand_offset();
    if (p < 45) begin
      txn(rand_addr(), 1'($urandom), 4'($urandom), 1'($urandom));
    end else if (p < 75) begin
      if (off >= sraf_pkg::OFF_REGION && $urandom_range(0, 1))
        send_item(sraf_pkg::KIND_WR, off, 4'd4, 1'b1,
                  ($urandom & 32'hFFFF_FF0F) |
                  (($urandom_range(0, 3) == 0) ? 32'd0 : 32'd1),
                  '0, 1'b0, 4'd0, 1'b0, gaps);
      else send_item(sraf_pkg::KIND_WR, off,
                     ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4,
                     $urandom_range(0, 5) != 0, $urandom, '0, 1'b0, 4'd0, 1'b0, gaps);
    end else if (p < 97) begin
      send_item(sraf_pkg::KIND_RD, off, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4,
                $urandom_range(0, 5) != 0, $urandom, '0, 1'b0, 4'd0, 1'b0, gaps);
    end else begin
      send_item(sraf_pkg::KIND_BAD, 16'($urandom), 4'($urandom), 1'($urandom), $urandom,
                {8'($urandom), $urandom}, 1'($urandom), 4'($urandom), 1'($urandom),
                gaps);
    end
  endtask

  task automatic test_random_traffic();
    reg_wr(sraf_pkg::OFF_GATE, 32'h1);
    for (int i = 0; i < 800; i++) begin
      if (i % 200 == 0) stall_enable = (i != 400);
      random_item(i % 200 < 150);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_rx = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        for (int i = 0; i < 20; i++) random_item(1'b0);
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    join
  endtask

  initial begin
    for (int i = 0; i < NR; i++) begin
      sh_base[i] = '0;
      sh_top[i] = (i == 0) ? AMASK : '0;
      sh_attr[i] = (i == 0) ? 32'hC000_0000 : '0;
      sh_idacc[i] = (i == 0) ? 32'hFFFF_FFFF : '0;
    end
    sh_action = '0; sh_gate = 0; sh_spec = '0; sh_pend = 0;
    sh_faddr = '0; sh_fflags = '0; sh_freq = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_registers();
    test_directed_regions();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (10) @(posedge clk_i);
    $display("covered %0d items, %0d results checked: %0d checks allowed, %0d denied",
             n_sent, n_checked, n_allowed, n_denied);
    if (errors == 0 && pending_verdicts.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/sraf_pkg.sv
hw/rtl/sraf_front.sv
hw/rtl/sraf_back.sv
hw/rtl/secure_region_access_filter_top.sv
sim/secure_region_access_filter_top_test.sv
